FILE: design/msfd_pkg.sv
`default_nettype none

package msfd_pkg;

    localparam logic [2:0] EV_PAYLOAD    = 3'd0;
    localparam logic [2:0] EV_GOOD       = 3'd1;
    localparam logic [2:0] EV_CRC_BAD    = 3'd2;
    localparam logic [2:0] EV_HDR_REJECT = 3'd3;
    localparam logic [2:0] EV_TIMEOUT    = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT     = 2'd2;

    localparam logic [7:0]  CFG_VERSION_RESET  = 8'd2;
    localparam logic [9:0]  CFG_MAX_PAY_RESET  = 10'd907;
    localparam logic [15:0] CFG_TIMEOUT_RESET  = 16'd250;

    localparam logic [7:0] MAGIC0 = 8'h4F; // 'O'
    localparam logic [7:0] MAGIC1 = 8'h46; // 'F'
    localparam logic [7:0] MAGIC2 = 8'h57; // 'W'
    localparam logic [7:0] MAGIC3 = 8'h32; // '2'

    localparam int POS_W        = 11;
    localparam int HDR_IDX_W    = 4;
    localparam int HEADER_BYTES = 12;

    localparam logic [POS_W-1:0]     MAGIC_BYTES   = 11'd4;
    localparam logic [POS_W-1:0]     HDR_BYTES_POS = 11'd12;
    localparam logic [POS_W-1:0]     TRAILER_BYTES = 11'd4;
    localparam logic [POS_W-1:0]     FRAME_OVERHEAD = 11'd16;
    localparam logic [HDR_IDX_W-1:0] HDR_CRC_SPAN  = 4'd10;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 4'd11;

    localparam logic [15:0] CRC16_POLY   = 16'h1021;
    localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
    localparam logic [31:0] CRC32C_POLY  = 32'h82F63B78;
    localparam logic [31:0] CRC32C_INIT  = 32'hFFFFFFFF;
    localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [9:0]  max_payload;
        logic [15:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic [3:0] magic_hit;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  msg_type;
        logic [15:0] sequence_number;
        logic [9:0]  frame_length;
        logic        version_fault;
        logic        length_fault;
        logic        header_crc_fault;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC32C_POLY : 32'h00000000);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/magic_synced_frame_deframer.sv
`default_nettype none

// Frame deframer for a byte link with millisecond ticks. Each input item is a received
// byte or a tick; the block hunts for the magic "OFW2", checks a 12-byte header
// (version, length limit, CRC-16-CCITT), streams payload bytes out one result per byte
// and ends the frame with good or bad status from the CRC-32C trailer. A partial frame
// is dropped with a timeout result once more than idle_timeout ticks pass without a
// byte. Throughput is one item per clock while m_tready stays high: items go through a
// two-entry queue into a parser that handles one item per cycle unless its output
// register is full and not taken, and results are registered there. Configuration
// takes effect on the next item and should be written while the block is idle.
module magic_synced_frame_deframer #(
    parameter int LENGTH_LIMIT = 1023
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic [0:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // payload_byte, msg_type, sequence_number, frame_length, version_fault,
    // length_fault, header_crc_fault, zero pad
    output logic [47:0]      m_tdata,
    output logic [2:0]       m_tuser,   // event_res
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    msfd_pkg::cfg_t    cfg_reg, cfg_next;
    msfd_pkg::item_t   front_item;
    msfd_pkg::item_t   q_item;
    msfd_pkg::result_t out_res;
    logic              q_valid, q_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                msfd_pkg::REG_EXPECTED_VERSION: cfg_next.expected_version = cfg_wdata[7:0];
                msfd_pkg::REG_MAX_PAYLOAD:      cfg_next.max_payload      = cfg_wdata[9:0];
                msfd_pkg::REG_IDLE_TIMEOUT:     cfg_next.idle_timeout     = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version <= msfd_pkg::CFG_VERSION_RESET;
            cfg_reg.max_payload      <= msfd_pkg::CFG_MAX_PAY_RESET;
            cfg_reg.idle_timeout     <= msfd_pkg::CFG_TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    msfd_front u_front (
        .kind    (s_tuser[0]),
        .rx_byte (s_tdata),
        .item    (front_item)
    );

    msfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    msfd_back #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .item      (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.event_res;
    assign m_tdata = {3'b000,
                      out_res.header_crc_fault,
                      out_res.length_fault,
                      out_res.version_fault,
                      out_res.frame_length,
                      out_res.sequence_number,
                      out_res.msg_type,
                      out_res.payload_byte};

`ifndef ASSERT_OFF
    a_empty_queue_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> s_tready)
        else $error("queue empty but input not ready");

    a_timeout_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.event_res == msfd_pkg::EV_TIMEOUT) |-> (m_tdata == 48'h0))
        else $error("timeout result carries non-zero fields");

    a_flags_only_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.event_res != msfd_pkg::EV_HDR_REJECT) |->
        !(out_res.version_fault || out_res.length_fault || out_res.header_crc_fault))
        else $error("fault flags on a non-reject result");

    a_reject_has_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.event_res == msfd_pkg::EV_HDR_REJECT) |->
        (out_res.version_fault || out_res.length_fault || out_res.header_crc_fault))
        else $error("header reject without a fault flag");
`endif

endmodule

`default_nettype wire

FILE: design/msfd_front.sv
`default_nettype none

module msfd_front (
    input  wire logic           kind,
    input  wire logic [7:0]     rx_byte,
    output msfd_pkg::item_t     item
);

    always_comb begin
        item.is_tick      = (kind == msfd_pkg::KIND_TICK);
        item.rx_byte      = rx_byte;
        item.magic_hit[0] = (rx_byte == msfd_pkg::MAGIC0);
        item.magic_hit[1] = (rx_byte == msfd_pkg::MAGIC1);
        item.magic_hit[2] = (rx_byte == msfd_pkg::MAGIC2);
        item.magic_hit[3] = (rx_byte == msfd_pkg::MAGIC3);
    end

endmodule

`default_nettype wire

FILE: design/msfd_queue.sv
`default_nettype none

module msfd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire msfd_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output msfd_pkg::item_t     pop_item
);

    msfd_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 2'd1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/msfd_back.sv
`default_nettype none

module msfd_back #(
    parameter int LENGTH_LIMIT = 1023
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire msfd_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire msfd_pkg::item_t item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output msfd_pkg::result_t   out_res
);

    localparam int PW = msfd_pkg::POS_W;
    localparam int IW = msfd_pkg::HDR_IDX_W;
    localparam logic [15:0] LEN_LIMIT = 16'(LENGTH_LIMIT);

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] frame_end_reg, frame_end_next;
    logic [15:0]   hcrc_reg, hcrc_next;
    logic [31:0]   fcrc_reg, fcrc_next;
    logic [31:0]   trailer_reg, trailer_next;
    logic [15:0]   idle_reg, idle_next;
    logic [7:0]    hdr_reg [msfd_pkg::HEADER_BYTES];

    logic               out_valid_reg, out_valid_next;
    msfd_pkg::result_t  out_res_reg;

    logic               in_fire;
    logic               emit;
    msfd_pkg::result_t  res;
    msfd_pkg::result_t  hdr_res;
    logic               take, take_start;
    logic [IW-1:0]      take_at;
    logic [15:0]        hbase;
    logic [31:0]        fbase;
    logic [15:0]        len;
    logic [15:0]        rx_crc;
    logic               vf, lf, cf;
    logic [7:0]         b;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign b      = item.rx_byte;
    assign len    = {hdr_reg[9], hdr_reg[8]};
    assign rx_crc = {b, hdr_reg[10]};

    always_comb begin
        hdr_res                  = '0;
        hdr_res.msg_type         = hdr_reg[5];
        hdr_res.sequence_number  = {hdr_reg[7], hdr_reg[6]};
        hdr_res.frame_length     = {hdr_reg[9][1:0], hdr_reg[8]};
    end

    always_comb begin
        pos_next       = pos_reg;
        frame_end_next = frame_end_reg;
        hcrc_next      = hcrc_reg;
        fcrc_next      = fcrc_reg;
        trailer_next   = trailer_reg;
        idle_next      = idle_reg;
        emit           = 1'b0;
        res            = hdr_res;
        take           = 1'b0;
        take_start     = 1'b0;
        take_at        = pos_reg[IW-1:0];
        vf             = 1'b0;
        lf             = 1'b0;
        cf             = 1'b0;
        hbase          = hcrc_reg;
        fbase          = fcrc_reg;

        if (in_fire) begin
            if (item.is_tick) begin
                idle_next = (idle_reg == msfd_pkg::IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
                if (pos_reg != '0 && idle_next > cfg.idle_timeout) begin
                    pos_next       = '0;
                    frame_end_next = '0;
                    trailer_next   = '0;
                    emit           = 1'b1;
                    res            = '0;
                    res.event_res  = msfd_pkg::EV_TIMEOUT;
                end
            end else begin
                idle_next = '0;
                if (pos_reg < msfd_pkg::MAGIC_BYTES) begin
                    if (item.magic_hit[pos_reg[1:0]]) begin
                        take       = 1'b1;
                        take_start = (pos_reg == '0);
                    end else if (item.magic_hit[0]) begin
                        take       = 1'b1;
                        take_start = 1'b1;
                        take_at    = '0;
                    end else begin
                        pos_next = '0;
                    end
                end else if (pos_reg < msfd_pkg::HDR_BYTES_POS) begin
                    take = 1'b1;
                end else if (pos_reg + msfd_pkg::TRAILER_BYTES < frame_end_reg) begin
                    fcrc_next         = msfd_pkg::crc32c_byte(fcrc_reg, b);
                    pos_next          = pos_reg + 11'd1;
                    emit              = 1'b1;
                    res.event_res     = msfd_pkg::EV_PAYLOAD;
                    res.payload_byte  = b;
                end else begin
                    trailer_next = {b, trailer_reg[31:8]};
                    pos_next     = pos_reg + 11'd1;
                    if (pos_reg + 11'd1 >= frame_end_reg) begin
                        emit          = 1'b1;
                        res.event_res = (~fcrc_reg == trailer_next) ?
                                        msfd_pkg::EV_GOOD : msfd_pkg::EV_CRC_BAD;
                        pos_next       = '0;
                        frame_end_next = '0;
                        trailer_next   = '0;
                    end
                end
            end
        end

        if (take) begin
            if (take_start) begin
                hbase        = msfd_pkg::CRC16_INIT;
                fbase        = msfd_pkg::CRC32C_INIT;
                trailer_next = '0;
            end
            hcrc_next = (take_at < msfd_pkg::HDR_CRC_SPAN) ?
                        msfd_pkg::crc16_byte(hbase, b) : hbase;
            fcrc_next = msfd_pkg::crc32c_byte(fbase, b);
            pos_next  = {{(PW-IW){1'b0}}, take_at} + 11'd1;
            if (take_at == msfd_pkg::HDR_LAST) begin
                vf = (hdr_reg[4] != cfg.expected_version);
                lf = (len > {6'b000000, cfg.max_payload}) || (len > LEN_LIMIT);
                cf = (hcrc_next != rx_crc);
                if (vf || lf || cf) begin
                    emit                 = 1'b1;
                    res.event_res        = msfd_pkg::EV_HDR_REJECT;
                    res.version_fault    = vf;
                    res.length_fault     = lf;
                    res.header_crc_fault = cf;
                    pos_next             = '0;
                    frame_end_next       = '0;
                    trailer_next         = '0;
                end else begin
                    frame_end_next = msfd_pkg::FRAME_OVERHEAD + {1'b0, len[9:0]};
                    trailer_next   = '0;
                end
            end
        end

        out_valid_next = in_ready ? emit : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            frame_end_reg <= '0;
            hcrc_reg      <= msfd_pkg::CRC16_INIT;
            fcrc_reg      <= msfd_pkg::CRC32C_INIT;
            trailer_reg   <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            frame_end_reg <= frame_end_next;
            hcrc_reg      <= hcrc_next;
            fcrc_reg      <= fcrc_next;
            trailer_reg   <= trailer_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            hdr_reg[take_at] <= b;
        end
        if (in_ready && emit) begin
            out_res_reg <= res;
        end
    end

endmodule

`default_nettype wire
